// ===== design/abe_pkg.sv =====
// package for the alu/branch execute unit: item types, action codes, widths
// no dependencies
package abe_pkg;

    localparam int DataWidth = 32;
    localparam int HalfWidth = DataWidth / 2;
    localparam int CntWidth  = $clog2(DataWidth + 1);

    localparam logic [4:0] ActMov  = 5'd0;
    localparam logic [4:0] ActAdd  = 5'd1;
    localparam logic [4:0] ActSub  = 5'd2;
    localparam logic [4:0] ActSwap = 5'd3;
    localparam logic [4:0] ActMul  = 5'd4;
    localparam logic [4:0] ActDiv  = 5'd5;
    localparam logic [4:0] ActCmp  = 5'd6;
    localparam logic [4:0] ActShl  = 5'd7;
    localparam logic [4:0] ActShr  = 5'd8;
    localparam logic [4:0] ActSar  = 5'd9;
    localparam logic [4:0] ActAnd  = 5'd10;
    localparam logic [4:0] ActOr   = 5'd11;
    localparam logic [4:0] ActXor  = 5'd12;
    localparam logic [4:0] ActLdl  = 5'd13;
    localparam logic [4:0] ActLdh  = 5'd14;
    localparam logic [4:0] ActNot  = 5'd15;
    localparam logic [4:0] ActJmp  = 5'd16;
    localparam logic [4:0] ActJz   = 5'd17;
    localparam logic [4:0] ActJp   = 5'd18;
    localparam logic [4:0] ActJn   = 5'd19;
    localparam logic [4:0] ActJnz  = 5'd20;
    localparam logic [4:0] ActJnp  = 5'd21;
    localparam logic [4:0] ActJnn  = 5'd22;
    localparam logic [4:0] ActStop = 5'd23;

    typedef struct packed {
        logic [4:0]  action;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic        write_a;
        logic [31:0] value_a;
        logic        write_b;
        logic [31:0] value_b;
        logic        negative_flag;
        logic        zero_flag;
        logic        jump_taken;
        logic [15:0] jump_target;
        logic [31:0] remainder_out;
        logic        halt;
        logic        invalid_op;
    } out_item_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [4:0]           action;
        logic [DataWidth-1:0] a;
        logic [DataWidth-1:0] b;
        logic                 big_shift;
        logic                 is_div;
        logic                 div_zero;
        logic                 invalid;
    } op_t;

endpackage

// ===== design/alu_branch_execute_nz_flags.sv =====
// top level of the alu/branch execute unit with n/z condition flags
// depends on abe_pkg, abe_front, abe_back (and abe_div below it)
//
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | in_data  (abe_pkg::in_item_t)
//  out     | out_valid / out_ready | out_data (abe_pkg::out_item_t)
//
// most items finish in the back end's idle state; mul passes through the StMul state
// a nonzero div passes through StDiv and StFix around the one-bit-per-cycle divider loop
// two-entry queue between front and back; output register holds a result
// until it is taken, and the next item is taken only when the output register has room
// reset clears flags, remainder, queue and output valid
module alu_branch_execute_nz_flags (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  abe_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output abe_pkg::out_item_t out_data
);
    import abe_pkg::*;

    logic op_valid, op_ready;
    op_t  op_data;

    abe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op_data  (op_data)
    );

    abe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op_data   (op_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_jump_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.jump_taken |-> out_data.jump_target == 16'd0)
        else $error("jump target set without a jump");

    a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.halt |-> !out_data.write_a && !out_data.write_b)
        else $error("write-back on a halting item");
endmodule

// ===== design/abe_front.sv =====
// front end: accepts items, classifies them, two-entry queue toward the back end
// depends on abe_pkg
module abe_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  abe_pkg::in_item_t in_data,
    output logic              op_valid,
    input  logic              op_ready,
    output abe_pkg::op_t      op_data
);
    import abe_pkg::*;

    op_t        q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    op_t        cls;
    logic       push, pop;

    always_comb
    begin
        cls.action    = in_data.action;
        cls.a         = in_data.operand_a[DataWidth-1:0];
        cls.b         = in_data.operand_b[DataWidth-1:0];
        cls.big_shift = (in_data.operand_b >= 32'(DataWidth));
        cls.is_div    = (in_data.action == ActDiv);
        cls.div_zero  = (in_data.operand_b[DataWidth-1:0] == '0);
        cls.invalid   = (in_data.action > ActStop);
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign op_valid = (count_reg != 2'd0);
    assign pop      = op_valid && op_ready;
    assign op_data  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== design/abe_div.sv =====
// iterative unsigned divider, one quotient bit per cycle
// depends on abe_pkg
module abe_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [abe_pkg::DataWidth-1:0] dividend,
    input  logic [abe_pkg::DataWidth-1:0] divisor,
    output logic                          done,
    output logic [abe_pkg::DataWidth-1:0] quotient,
    output logic [abe_pkg::DataWidth-1:0] remainder
);
    import abe_pkg::*;

    logic [DataWidth-1:0] quo_reg, quo_next, rem_reg, rem_next, dsr_reg;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next, done_reg, done_next;
    logic [DataWidth:0]   trial;

    assign trial     = {rem_reg, quo_reg[DataWidth-1]} - {1'b0, dsr_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CntWidth'(DataWidth);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[DataWidth])
            begin
                rem_next = {rem_reg[DataWidth-2:0], quo_reg[DataWidth-1]};
                quo_next = {quo_reg[DataWidth-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DataWidth-1:0];
                quo_next = {quo_reg[DataWidth-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end
endmodule

// ===== design/abe_back.sv =====
// back end: executes classified items, holds flags and remainder, output register
// depends on abe_pkg, abe_div
module abe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_ready,
    input  abe_pkg::op_t       op_data,
    output logic               out_valid,
    input  logic               out_ready,
    output abe_pkg::out_item_t out_data
);
    import abe_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StMul  = 2'd1;
    localparam logic [1:0] StDiv  = 2'd2;
    localparam logic [1:0] StFix  = 2'd3;

    localparam int ShWidth = $clog2(DataWidth);

    logic [1:0]           state_reg, state_next;
    logic                 neg_reg, neg_next, zero_reg, zero_next;
    logic [DataWidth-1:0] rem_reg, rem_next;
    logic                 ovalid_reg, ovalid_next;
    out_item_t            odata_reg, odata_next;
    op_t                  cur_reg;
    logic [DataWidth-1:0] prod_reg, mag_q_reg, mag_r_reg;
    logic                 sa, sb, take, room;
    logic [DataWidth-1:0] ma, mb, r, va, half_mask;
    logic                 flg, wa, jt;
    logic                 div_start, div_done;
    logic                 div_go_reg, div_go_next;
    logic [DataWidth-1:0] div_q, div_r;
    logic [ShWidth-1:0]   sh;

    abe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (ma),
        .divisor   (mb),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign room      = !ovalid_reg || out_ready;
    assign op_ready  = (state_reg == StIdle) && room;
    assign take      = op_valid && op_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign half_mask = {{(DataWidth-HalfWidth){1'b0}}, {HalfWidth{1'b1}}};
    assign sh        = op_data.b[ShWidth-1:0];

    assign sa        = cur_reg.a[DataWidth-1];
    assign sb        = cur_reg.b[DataWidth-1];
    assign ma        = sa ? (DataWidth'(0) - cur_reg.a) : cur_reg.a;
    assign mb        = sb ? (DataWidth'(0) - cur_reg.b) : cur_reg.b;
    // divider starts in the cycle after a nonzero div is taken, once cur_reg holds it
    assign div_go_next = take && (op_data.action == ActDiv) && !op_data.div_zero;
    assign div_start   = div_go_reg;

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        rem_next    = rem_reg;
        ovalid_next = ovalid_reg && !out_ready;
        odata_next  = odata_reg;
        r           = '0;
        va          = '0;
        flg         = 1'b0;
        wa          = 1'b0;
        jt          = 1'b0;
        unique case (state_reg)
            StIdle:
            begin
                if (take)
                begin
                    odata_next = '0;
                    unique case (op_data.action)
                        ActMov:  begin wa = 1'b1; va = op_data.b; end
                        ActAdd:  begin r = op_data.a + op_data.b; flg = 1'b1; end
                        ActSub:  begin r = op_data.a - op_data.b; flg = 1'b1; end
                        ActSwap:
                        begin
                            wa = 1'b1;
                            va = op_data.b;
                            odata_next.write_b = 1'b1;
                            odata_next.value_b = 32'(op_data.a);
                        end
                        ActMul:  state_next = StMul;
                        ActDiv:  state_next = op_data.div_zero ? StIdle : StDiv;
                        ActCmp:
                        begin
                            r         = op_data.a - op_data.b;
                            neg_next  = r[DataWidth-1];
                            zero_next = (r == '0);
                        end
                        ActShl:  begin r = op_data.big_shift ? '0 : op_data.a << sh; flg = 1'b1; end
                        ActShr:  begin r = op_data.big_shift ? '0 : op_data.a >> sh; flg = 1'b1; end
                        ActSar:
                        begin
                            r   = op_data.big_shift ? {DataWidth{op_data.a[DataWidth-1]}}
                                                    : DataWidth'($signed(op_data.a) >>> sh);
                            flg = 1'b1;
                        end
                        ActAnd:  begin r = op_data.a & op_data.b; flg = 1'b1; end
                        ActOr:   begin r = op_data.a | op_data.b; flg = 1'b1; end
                        ActXor:  begin r = op_data.a ^ op_data.b; flg = 1'b1; end
                        ActLdl:
                        begin
                            wa = 1'b1;
                            va = (op_data.a & ~half_mask) | (op_data.b & half_mask);
                        end
                        ActLdh:
                        begin
                            wa = 1'b1;
                            va = (op_data.b << HalfWidth) | (op_data.a & half_mask);
                        end
                        ActNot:  begin wa = 1'b1; va = ~op_data.a; end
                        ActJmp:  jt = 1'b1;
                        ActJz:   jt = zero_reg;
                        ActJp:   jt = !zero_reg && !neg_reg;
                        ActJn:   jt = neg_reg;
                        ActJnz:  jt = !zero_reg;
                        ActJnp:  jt = zero_reg || neg_reg;
                        ActJnn:  jt = !neg_reg;
                        default: ;
                    endcase
                    if (flg)
                    begin
                        neg_next  = r[DataWidth-1];
                        zero_next = (r == '0);
                        wa        = 1'b1;
                        va        = r;
                    end
                    // multi-cycle ops emit their result later
                    if (!(op_data.action == ActMul ||
                          (op_data.action == ActDiv && !op_data.div_zero)))
                    begin
                        ovalid_next              = 1'b1;
                        odata_next.write_a       = wa;
                        odata_next.value_a       = wa ? 32'(va) : '0;
                        odata_next.negative_flag = neg_next;
                        odata_next.zero_flag     = zero_next;
                        odata_next.jump_taken    = jt;
                        odata_next.jump_target   = jt ? op_data.a[15:0] : '0;
                        odata_next.remainder_out = 32'(rem_next);
                        odata_next.halt          = (op_data.action == ActStop) ||
                                                   (op_data.action == ActDiv);
                        odata_next.invalid_op    = op_data.invalid;
                    end
                end
            end
            StMul:
            begin
                if (room)
                begin
                    neg_next    = prod_reg[DataWidth-1];
                    zero_next   = (prod_reg == '0);
                    ovalid_next = 1'b1;
                    odata_next  = '0;
                    odata_next.write_a       = 1'b1;
                    odata_next.value_a       = 32'(prod_reg);
                    odata_next.negative_flag = neg_next;
                    odata_next.zero_flag     = zero_next;
                    odata_next.remainder_out = 32'(rem_reg);
                    state_next  = StIdle;
                end
            end
            StDiv:
            begin
                if (div_done)
                begin
                    state_next = StFix;
                end
            end
            StFix:
            begin
                if (room)
                begin
                    r           = (sa != sb) ? (DataWidth'(0) - mag_q_reg) : mag_q_reg;
                    rem_next    = sa ? (DataWidth'(0) - mag_r_reg) : mag_r_reg;
                    neg_next    = r[DataWidth-1];
                    zero_next   = (r == '0);
                    ovalid_next = 1'b1;
                    odata_next  = '0;
                    odata_next.write_a       = 1'b1;
                    odata_next.value_a       = 32'(r);
                    odata_next.negative_flag = neg_next;
                    odata_next.zero_flag     = zero_next;
                    odata_next.remainder_out = 32'(rem_next);
                    state_next  = StIdle;
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        if (take)
        begin
            cur_reg  <= op_data;
            prod_reg <= DataWidth'(op_data.a * op_data.b);
        end
        if (div_done)
        begin
            mag_q_reg <= div_q;
            mag_r_reg <= div_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= StIdle;
            neg_reg    <= 1'b0;
            zero_reg   <= 1'b0;
            rem_reg    <= '0;
            ovalid_reg <= 1'b0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            neg_reg    <= neg_next;
            zero_reg   <= zero_next;
            rem_reg    <= rem_next;
            ovalid_reg <= ovalid_next;
            div_go_reg <= div_go_next;
        end
    end
endmodule

// ===== test/alu_branch_execute_nz_flags_tb.sv =====
// testbench for the alu/branch execute unit with n/z condition flags
// depends on abe_pkg and alu_branch_execute_nz_flags; self-checking with
// a flag-tracking predictor and an in-order result queue
module alu_branch_execute_nz_flags_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import abe_pkg::*;

    class exec_scoreboard;
        out_item_t pending[$];
        logic      neg_q;
        logic      zero_q;
        logic [31:0] rem_q;
        int        errors;

        function new();
            neg_q  = 1'b0;
            zero_q = 1'b0;
            rem_q  = '0;
            errors = 0;
        endfunction

        function void note_item(in_item_t it);
            out_item_t   o;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] r;
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            logic [31:0] rm;
            logic        upd;
            a   = it.operand_a;
            b   = it.operand_b;
            r   = '0;
            upd = 1'b0;
            o   = '0;
            case (it.action)
                ActMov: begin o.write_a = 1'b1; o.value_a = b; end
                ActAdd: begin r = a + b; upd = 1'b1; end
                ActSub: begin r = a - b; upd = 1'b1; end
                ActSwap:
                begin
                    o.write_a = 1'b1; o.value_a = b; o.write_b = 1'b1; o.value_b = a;
                end
                ActMul: begin r = a * b; upd = 1'b1; end
                ActDiv:
                begin
                    if (b == 0)
                        o.halt = 1'b1;
                    else
                    begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q  = ma / mb;
                        rm = ma % mb;
                        if (a[31] != b[31])
                            q = -q;
                        if (a[31])
                            rm = -rm;
                        r     = q;
                        rem_q = rm;
                        upd   = 1'b1;
                    end
                end
                ActCmp:
                begin
                    r      = a - b;
                    neg_q  = r[31];
                    zero_q = (r == 0);
                end
                ActShl: begin r = (b >= 32) ? '0 : a << b[4:0]; upd = 1'b1; end
                ActShr: begin r = (b >= 32) ? '0 : a >> b[4:0]; upd = 1'b1; end
                ActSar:
                begin
                    r   = (b >= 32) ? {32{a[31]}} : $unsigned($signed(a) >>> b[4:0]);
                    upd = 1'b1;
                end
                ActAnd: begin r = a & b; upd = 1'b1; end
                ActOr:  begin r = a | b; upd = 1'b1; end
                ActXor: begin r = a ^ b; upd = 1'b1; end
                ActLdl: begin o.write_a = 1'b1; o.value_a = {a[31:16], b[15:0]}; end
                ActLdh: begin o.write_a = 1'b1; o.value_a = {b[15:0], a[15:0]}; end
                ActNot: begin o.write_a = 1'b1; o.value_a = ~a; end
                ActJmp: o.jump_taken = 1'b1;
                ActJz:  o.jump_taken = zero_q;
                ActJp:  o.jump_taken = !zero_q && !neg_q;
                ActJn:  o.jump_taken = neg_q;
                ActJnz: o.jump_taken = !zero_q;
                ActJnp: o.jump_taken = zero_q || neg_q;
                ActJnn: o.jump_taken = !neg_q;
                ActStop: o.halt = 1'b1;
                default: o.invalid_op = 1'b1;
            endcase
            if (upd)
            begin
                neg_q     = r[31];
                zero_q    = (r == 0);
                o.write_a = 1'b1;
                o.value_a = r;
            end
            if (o.jump_taken)
                o.jump_target = a[15:0];
            o.negative_flag = neg_q;
            o.zero_flag     = zero_q;
            o.remainder_out = rem_q;
            pending.push_back(o);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.write_a !== e.write_a) begin $error("write_a exp %h got %h", e.write_a, got.write_a); errors++; end
            if (got.value_a !== e.value_a) begin $error("value_a exp %h got %h", e.value_a, got.value_a); errors++; end
            if (got.write_b !== e.write_b) begin $error("write_b exp %h got %h", e.write_b, got.write_b); errors++; end
            if (got.value_b !== e.value_b) begin $error("value_b exp %h got %h", e.value_b, got.value_b); errors++; end
            if (got.negative_flag !== e.negative_flag)
            begin
                $error("negative_flag exp %h got %h", e.negative_flag, got.negative_flag);
                errors++;
            end
            if (got.zero_flag !== e.zero_flag)
            begin
                $error("zero_flag exp %h got %h", e.zero_flag, got.zero_flag);
                errors++;
            end
            if (got.jump_taken !== e.jump_taken)
            begin
                $error("jump_taken exp %h got %h", e.jump_taken, got.jump_taken);
                errors++;
            end
            if (got.jump_target !== e.jump_target)
            begin
                $error("jump_target exp %h got %h", e.jump_target, got.jump_target);
                errors++;
            end
            if (got.remainder_out !== e.remainder_out)
            begin
                $error("remainder_out exp %h got %h", e.remainder_out, got.remainder_out);
                errors++;
            end
            if (got.halt !== e.halt) begin $error("halt exp %h got %h", e.halt, got.halt); errors++; end
            if (got.invalid_op !== e.invalid_op)
            begin
                $error("invalid_op exp %h got %h", e.invalid_op, got.invalid_op);
                errors++;
            end
        endfunction
    endclass

    localparam int StallLimit = 2000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    exec_scoreboard sb;
    bit  hold_off;
    int  idle_cycles;

    alu_branch_execute_nz_flags dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return '0;
            3: return $urandom_range(0, 40);
            4: return -$urandom_range(1, 40);
            5: return 32'h0000_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // offers one item and waits for it to be taken
    task automatic send_item(logic [4:0] act, logic [31:0] a, logic [31:0] b);
        in_item_t it;
        it.action    = act;
        it.operand_a = a;
        it.operand_b = b;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic send_gapped(logic [4:0] act, logic [31:0] a, logic [31:0] b);
        int g;
        send_item(act, a, b);
        g = pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls, plus a long hold-off when asked
    initial
    begin
        int g;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (hold_off)
                out_ready <= 1'b0;
            else if (g > 0)
            begin
                out_ready <= 1'b0;
                g--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    g = pick_gap();
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [4:0]  act;
        logic [31:0] a;
        logic [31:0] b;
        sb          = new();
        hold_off    = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, division corners, shifts, flags, jumps
        send_item(ActJz,   32'h0001_2345, '0);
        send_item(ActAdd,  32'hFFFF_FFFF, 32'h1);
        send_item(ActJz,   32'hABCD_FFFF, '0);
        send_item(ActDiv,  32'h8000_0000, 32'hFFFF_FFFF);
        send_item(ActDiv,  32'hFFFF_FFF9, 32'h2);
        send_item(ActDiv,  32'h7, 32'hFFFF_FFFE);
        send_item(ActDiv,  32'h1234, '0);
        send_item(ActShl,  32'hFFFF_FFFF, 32'd32);
        send_item(ActShr,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(ActSar,  32'h8000_0000, 32'd40);
        send_item(ActSar,  32'h8000_0000, 32'd31);
        send_item(ActMul,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(ActCmp,  32'h1, 32'h2);
        send_item(ActJn,   32'hFFFF_FFFF, '0);
        send_item(ActJnn,  32'h5, '0);
        send_item(ActSwap, 32'hDEAD_BEEF, 32'h1234_5678);
        send_item(ActLdl,  32'hFFFF_FFFF, 32'h0);
        send_item(ActLdh,  32'h0, 32'hFFFF_FFFF);
        send_item(ActNot,  32'h0, 32'h0);
        send_item(ActStop, 32'h0, 32'h0);
        send_item(5'd31,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(ActMov,  32'h0, 32'hFFFF_FFFF);
        send_item(ActJp,   32'h0000_FFFF, '0);
        drain();

        // random body with a long result hold-off in the middle
        for (int n = 0; n < 1150; n++)
        begin
            if (n == 400)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (n == 800)
                drain();
            act = $urandom_range(0, 99) < 5 ? 5'($urandom_range(24, 31))
                                            : 5'($urandom_range(0, 23));
            a = pick_value();
            b = pick_value();
            if ((act == ActShl || act == ActShr || act == ActSar) && $urandom_range(0, 3) != 0)
                b = $urandom_range(0, 40);
            if (n < 200)
                send_item(act, a, b);
            else
                send_gapped(act, a, b);
        end
        drain();
        repeat (50) @(posedge clk);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
